// ----- sv/name_registry_table_unit_defines.svh -----
// ----------------------------------------------------------------------------
// Name registry table assertion macros
// Concurrent check wrappers shared by the table modules. The checks are left
// out when the code is read for synthesis.
// ----------------------------------------------------------------------------
`ifndef NAME_REGISTRY_TABLE_UNIT_DEFINES_SVH
`define NAME_REGISTRY_TABLE_UNIT_DEFINES_SVH
`ifndef SYNTHESIS
// A property that must hold at every clock edge out of reset.
`define NRT_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) else $error(msg);
// A consequent that must hold in the same cycle as its antecedent.
`define NRT_IMPLY(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);
`else
`define NRT_ASSERT(lbl, prop, msg)
`define NRT_IMPLY(lbl, ante, cons, msg)
`endif
`endif

// ----- sv/nrt_pkg.sv -----
// ----------------------------------------------------------------------------
// Name registry table package
// Widths, command, status and operation codes, and the job item type that
// travels from the front end through the queue to the back end.
// ----------------------------------------------------------------------------
package nrt_pkg;

    // Default sizes of the table.
    localparam int MAX_ENTRIES_DEF = 32;
    localparam int NAME_BYTES_DEF  = 16;

    // Fixed field widths.
    localparam int NAME_BYTES_MAX = 16;
    localparam int NAME_W         = 8 * NAME_BYTES_MAX;
    localparam int HALF_W         = NAME_W / 2;
    localparam int CMD_W          = 3;
    localparam int IDX_W          = 5;
    localparam int STATUS_W       = 3;
    localparam int COUNT_OUT_W    = 6;
    localparam int OP_W           = 3;

    // Depth of the queue between the front and back ends.
    localparam int QUEUE_DEPTH = 2;

    // Command codes.
    localparam logic [CMD_W-1:0] CMD_REGISTER   = 3'd0;
    localparam logic [CMD_W-1:0] CMD_UNREGISTER = 3'd1;
    localparam logic [CMD_W-1:0] CMD_MATCH      = 3'd2;
    localparam logic [CMD_W-1:0] CMD_READ       = 3'd3;
    localparam logic [CMD_W-1:0] CMD_CLEAR      = 3'd4;

    // Status codes.
    localparam logic [STATUS_W-1:0] ST_OK       = 3'd0;
    localparam logic [STATUS_W-1:0] ST_PERM     = 3'd1;
    localparam logic [STATUS_W-1:0] ST_INVALID  = 3'd2;
    localparam logic [STATUS_W-1:0] ST_EXISTS   = 3'd3;
    localparam logic [STATUS_W-1:0] ST_FULL     = 3'd4;
    localparam logic [STATUS_W-1:0] ST_NOTFOUND = 3'd5;

    // Back end operations chosen by the front end.
    localparam logic [OP_W-1:0] OP_IMM    = 3'd0;
    localparam logic [OP_W-1:0] OP_CLEAR  = 3'd1;
    localparam logic [OP_W-1:0] OP_READ   = 3'd2;
    localparam logic [OP_W-1:0] OP_REG    = 3'd3;
    localparam logic [OP_W-1:0] OP_UNREG  = 3'd4;
    localparam logic [OP_W-1:0] OP_MATCH  = 3'd5;

    // One classified item: operation, preset status, read index and the
    // normalized name, high bytes in the upper half.
    typedef struct packed {
        logic [OP_W-1:0]     op;
        logic [STATUS_W-1:0] status;
        logic [IDX_W-1:0]    idx;
        logic [NAME_W-1:0]   name;
    } t_job;

endpackage

// ----- sv/nrt_front.sv -----
// ----------------------------------------------------------------------------
// Name registry table front end
// Accepts items, normalizes the name, checks privilege and name form, and
// holds the classified job until the queue takes it.
// ----------------------------------------------------------------------------
module nrt_front #(
    parameter int NAME_BYTES = nrt_pkg::NAME_BYTES_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_stall,
    input  logic [nrt_pkg::CMD_W-1:0]     i_cmd,
    input  logic                          i_privileged,
    input  logic [nrt_pkg::HALF_W-1:0]    i_name_low,
    input  logic [nrt_pkg::HALF_W-1:0]    i_name_high,
    input  logic [nrt_pkg::IDX_W-1:0]     i_entry_index,
    output logic                          o_push,
    output nrt_pkg::t_job                 o_job,
    input  logic                          i_full
);

    logic [nrt_pkg::NAME_W-1:0] raw_name;
    logic [nrt_pkg::NAME_W-1:0] norm_name;
    logic                       terminated;
    logic                       bad_name;
    logic                       accept;
    nrt_pkg::t_job              job_in;
    logic                       r_valid;
    logic                       n_valid;
    nrt_pkg::t_job              r_job;

    // Keep bytes up to and including the first zero; clear the rest.
    always_comb begin
        raw_name   = {i_name_high, i_name_low};
        norm_name  = '0;
        terminated = 1'b0;
        for (int i = 0; i < nrt_pkg::NAME_BYTES_MAX; i++) begin
            if (i < NAME_BYTES && !terminated) begin
                norm_name[8*i +: 8] = raw_name[8*i +: 8];
                if (raw_name[8*i +: 8] == 8'd0) begin
                    terminated = 1'b1;
                end
            end
        end
    end

    // An empty or unterminated name is invalid.
    assign bad_name = (norm_name[7:0] == 8'd0) || !terminated;

    // Classify the command into a back end operation.
    always_comb begin
        job_in.op     = nrt_pkg::OP_IMM;
        job_in.status = nrt_pkg::ST_OK;
        job_in.idx    = i_entry_index;
        job_in.name   = norm_name;
        case (i_cmd)
            nrt_pkg::CMD_REGISTER, nrt_pkg::CMD_UNREGISTER: begin
                if (!i_privileged) begin
                    job_in.status = nrt_pkg::ST_PERM;
                end else if (bad_name) begin
                    job_in.status = nrt_pkg::ST_INVALID;
                end else if (i_cmd == nrt_pkg::CMD_REGISTER) begin
                    job_in.op = nrt_pkg::OP_REG;
                end else begin
                    job_in.op = nrt_pkg::OP_UNREG;
                end
            end
            nrt_pkg::CMD_MATCH: begin
                // A name that cannot be stored never matches.
                if (!bad_name) begin
                    job_in.op = nrt_pkg::OP_MATCH;
                end
            end
            nrt_pkg::CMD_READ: begin
                job_in.op = nrt_pkg::OP_READ;
            end
            nrt_pkg::CMD_CLEAR: begin
                job_in.op = nrt_pkg::OP_CLEAR;
            end
            default: begin
                job_in.op = nrt_pkg::OP_IMM;
            end
        endcase
    end

    // Holding register toward the queue.
    assign o_stall = r_valid && i_full;
    assign accept  = i_valid && !o_stall;
    assign o_push  = r_valid && !i_full;
    assign o_job   = r_job;
    assign n_valid = accept || (r_valid && i_full);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_job <= job_in;
        end
    end

endmodule

// ----- sv/nrt_queue.sv -----
// ----------------------------------------------------------------------------
// Name registry table job queue
// A short first-in first-out queue of classified jobs that decouples the
// front end from the back end.
// ----------------------------------------------------------------------------
`include "name_registry_table_unit_defines.svh"

module nrt_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  nrt_pkg::t_job i_job,
    output logic          o_full,
    input  logic          i_pop,
    output logic          o_valid,
    output nrt_pkg::t_job o_job
);

    localparam int DEPTH = nrt_pkg::QUEUE_DEPTH;
    localparam int PW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int FW    = $clog2(DEPTH + 1);

    nrt_pkg::t_job  r_slot [DEPTH];
    logic [PW-1:0]  r_wptr;
    logic [PW-1:0]  r_rptr;
    logic [FW-1:0]  r_fill;
    logic [PW-1:0]  n_wptr;
    logic [PW-1:0]  n_rptr;
    logic [FW-1:0]  n_fill;

    assign o_full  = (r_fill == FW'(DEPTH));
    assign o_valid = (r_fill != '0);
    assign o_job   = r_slot[r_rptr];

    // Pointer and fill updates with wrap at the queue depth.
    always_comb begin
        n_wptr = r_wptr;
        n_rptr = r_rptr;
        n_fill = r_fill;
        if (i_push) begin
            n_wptr = (r_wptr == PW'(DEPTH - 1)) ? '0 : r_wptr + PW'(1);
        end
        if (i_pop) begin
            n_rptr = (r_rptr == PW'(DEPTH - 1)) ? '0 : r_rptr + PW'(1);
        end
        if (i_push && !i_pop) begin
            n_fill = r_fill + FW'(1);
        end else if (i_pop && !i_push) begin
            n_fill = r_fill - FW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= '0;
            r_rptr <= '0;
            r_fill <= '0;
        end else begin
            r_wptr <= n_wptr;
            r_rptr <= n_rptr;
            r_fill <= n_fill;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wptr] <= i_job;
        end
    end

    `NRT_IMPLY(a_q_no_overflow, i_push, !o_full, "job pushed into a full queue")
    `NRT_IMPLY(a_q_no_underflow, i_pop, o_valid, "job popped from an empty queue")
    `NRT_ASSERT(a_q_fill_max, r_fill <= FW'(DEPTH), "queue fill above its depth")

endmodule

// ----- sv/nrt_back.sv -----
// ----------------------------------------------------------------------------
// Name registry table back end
// Holds the name memory and the entry count and carries out one job at a
// time: scans for a name one entry per cycle, appends, shifts entries down
// after a removal, reads an entry, and loads the result register.
// ----------------------------------------------------------------------------
`include "name_registry_table_unit_defines.svh"

module nrt_back #(
    parameter int MAX_ENTRIES = nrt_pkg::MAX_ENTRIES_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_q_valid,
    input  nrt_pkg::t_job                     i_q_job,
    output logic                              o_pop,
    output logic                              o_valid,
    input  logic                              i_stall,
    output logic [nrt_pkg::STATUS_W-1:0]      o_status,
    output logic                              o_matched,
    output logic [nrt_pkg::COUNT_OUT_W-1:0]   o_entry_count,
    output logic                              o_entry_valid,
    output logic [nrt_pkg::HALF_W-1:0]        o_entry_name_low,
    output logic [nrt_pkg::HALF_W-1:0]        o_entry_name_high
);

    localparam int AW   = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int CW   = $clog2(MAX_ENTRIES + 1);
    localparam int CMPW = (CW > nrt_pkg::IDX_W) ? CW : nrt_pkg::IDX_W;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_SCAN  = 3'd1;
    localparam logic [2:0] S_SHIFT = 3'd2;
    localparam logic [2:0] S_READ  = 3'd3;
    localparam logic [2:0] S_DONE  = 3'd4;

    typedef struct packed {
        logic [nrt_pkg::STATUS_W-1:0] status;
        logic                         matched;
        logic                         valid;
        logic [nrt_pkg::NAME_W-1:0]   name;
    } t_result;

    // Name memory, one row per entry.
    logic [nrt_pkg::NAME_W-1:0] r_mem [MAX_ENTRIES];
    logic [nrt_pkg::NAME_W-1:0] r_rd_data;
    logic                       rd_en;
    logic [AW-1:0]              rd_addr;
    logic                       wr_en;
    logic [AW-1:0]              wr_addr;
    logic [nrt_pkg::NAME_W-1:0] wr_data;

    // Sequencer state.
    logic [2:0]    r_state, n_state;
    nrt_pkg::t_job r_job, n_job;
    t_result       r_res, n_res;
    logic [CW-1:0] r_count, n_count;
    logic [CW-1:0] r_k, n_k;
    logic          r_cmp_valid, n_cmp_valid;
    logic [CW-1:0] r_cmp_idx, n_cmp_idx;
    logic          r_wr_pend, n_wr_pend;
    logic [AW-1:0] r_wr_addr, n_wr_addr;
    logic [CW-1:0] k_minus_one;
    logic          hit;
    logic          out_load;

    // Output register.
    logic                               r_out_valid;
    logic [nrt_pkg::STATUS_W-1:0]       r_out_status;
    logic                               r_out_matched;
    logic [nrt_pkg::COUNT_OUT_W-1:0]    r_out_count;
    logic                               r_out_entry_valid;
    logic [nrt_pkg::NAME_W-1:0]         r_out_name;

    assign k_minus_one = r_k - CW'(1);
    assign hit         = r_cmp_valid && (r_rd_data == r_job.name);
    assign o_pop       = (r_state == S_IDLE) && i_q_valid;

    // Job sequencer.
    always_comb begin
        n_state     = r_state;
        n_job       = r_job;
        n_res       = r_res;
        n_count     = r_count;
        n_k         = r_k;
        n_cmp_valid = 1'b0;
        n_cmp_idx   = r_k;
        n_wr_pend   = 1'b0;
        n_wr_addr   = k_minus_one[AW-1:0];
        rd_en       = 1'b0;
        rd_addr     = r_k[AW-1:0];
        wr_en       = 1'b0;
        wr_addr     = r_wr_addr;
        wr_data     = r_rd_data;
        out_load    = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (i_q_valid) begin
                    n_job          = i_q_job;
                    n_res          = '0;
                    n_res.status   = i_q_job.status;
                    n_k            = '0;
                    case (i_q_job.op)
                        nrt_pkg::OP_CLEAR: begin
                            n_count = '0;
                            n_state = S_DONE;
                        end
                        nrt_pkg::OP_READ: begin
                            if (CMPW'(i_q_job.idx) < CMPW'(r_count)) begin
                                rd_en   = 1'b1;
                                rd_addr = AW'(i_q_job.idx);
                                n_state = S_READ;
                            end else begin
                                n_state = S_DONE;
                            end
                        end
                        nrt_pkg::OP_REG, nrt_pkg::OP_UNREG, nrt_pkg::OP_MATCH: begin
                            n_state = S_SCAN;
                        end
                        default: begin
                            n_state = S_DONE;
                        end
                    endcase
                end
            end
            S_SCAN: begin
                if (hit) begin
                    // The name is stored at the compared position.
                    case (r_job.op)
                        nrt_pkg::OP_MATCH: begin
                            n_res.matched = 1'b1;
                            n_state       = S_DONE;
                        end
                        nrt_pkg::OP_REG: begin
                            n_res.status = nrt_pkg::ST_EXISTS;
                            n_state      = S_DONE;
                        end
                        default: begin
                            n_k     = r_cmp_idx + CW'(1);
                            n_state = S_SHIFT;
                        end
                    endcase
                end else if (!r_cmp_valid && (r_k >= r_count)) begin
                    // Every stored entry was compared without a hit.
                    case (r_job.op)
                        nrt_pkg::OP_REG: begin
                            if (r_count >= CW'(MAX_ENTRIES)) begin
                                n_res.status = nrt_pkg::ST_FULL;
                            end else begin
                                wr_en   = 1'b1;
                                wr_addr = r_count[AW-1:0];
                                wr_data = r_job.name;
                                n_count = r_count + CW'(1);
                            end
                        end
                        nrt_pkg::OP_UNREG: begin
                            n_res.status = nrt_pkg::ST_NOTFOUND;
                        end
                        default: begin
                            n_res.matched = 1'b0;
                        end
                    endcase
                    n_state = S_DONE;
                end else begin
                    // Read the next entry; it is compared in the following cycle.
                    if (r_k < r_count) begin
                        rd_en       = 1'b1;
                        n_k         = r_k + CW'(1);
                        n_cmp_valid = 1'b1;
                    end
                end
            end
            S_SHIFT: begin
                // Each later entry moves down one place, read then written.
                if (r_wr_pend) begin
                    wr_en = 1'b1;
                end
                if (r_k < r_count) begin
                    rd_en     = 1'b1;
                    n_k       = r_k + CW'(1);
                    n_wr_pend = 1'b1;
                end else if (!r_wr_pend) begin
                    n_count = r_count - CW'(1);
                    n_state = S_DONE;
                end
            end
            S_READ: begin
                n_res.valid = 1'b1;
                n_res.name  = r_rd_data;
                n_state     = S_DONE;
            end
            S_DONE: begin
                if (!r_out_valid || !i_stall) begin
                    out_load = 1'b1;
                    n_state  = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_cmp_valid <= 1'b0;
            r_wr_pend   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_cmp_valid <= n_cmp_valid;
            r_wr_pend   <= n_wr_pend;
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Working registers of the current job.
    always_ff @(posedge i_clk) begin
        r_job     <= n_job;
        r_res     <= n_res;
        r_k       <= n_k;
        r_cmp_idx <= n_cmp_idx;
        r_wr_addr <= n_wr_addr;
    end

    // Name memory with a registered read port.
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            r_rd_data <= r_mem[rd_addr];
        end
    end

    // Result register payload.
    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out_status      <= r_res.status;
            r_out_matched     <= r_res.matched;
            r_out_count       <= nrt_pkg::COUNT_OUT_W'(r_count);
            r_out_entry_valid <= r_res.valid;
            r_out_name        <= r_res.name;
        end
    end

    assign o_valid           = r_out_valid;
    assign o_status          = r_out_status;
    assign o_matched         = r_out_matched;
    assign o_entry_count     = r_out_count;
    assign o_entry_valid     = r_out_entry_valid;
    assign o_entry_name_low  = r_out_name[nrt_pkg::HALF_W-1:0];
    assign o_entry_name_high = r_out_name[nrt_pkg::NAME_W-1:nrt_pkg::HALF_W];

    `NRT_ASSERT(a_count_max, r_count <= CW'(MAX_ENTRIES), "entry count above table size")
    `NRT_IMPLY(a_count_at_done, $past(i_rst_n) && (r_count != $past(r_count)), r_state == S_DONE, "entry count changed outside job completion")
    `NRT_IMPLY(a_out_from_done, $rose(r_out_valid), $past(r_state == S_DONE), "result raised without a finished job")

endmodule

// ----- sv/name_registry_table_unit.sv -----
// Back end: one item at a time, each finished before the next is popped from the queue;
// scans and shifts are paced by the single read port of the name memory.
// Reset: synchronous, active low; clears the count and all control, no clearing pass.
// ----------------------------------------------------------------------------
// Name registry table
// Table of distinct zero-terminated names with register, unregister, match,
// read entry and clear commands; front end, job queue and back end.
// ----------------------------------------------------------------------------
module name_registry_table_unit #(
    parameter int MAX_ENTRIES = nrt_pkg::MAX_ENTRIES_DEF,
    parameter int NAME_BYTES  = nrt_pkg::NAME_BYTES_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  logic [nrt_pkg::CMD_W-1:0]         i_cmd,
    input  logic                              i_privileged,
    input  logic [nrt_pkg::HALF_W-1:0]        i_name_low,
    input  logic [nrt_pkg::HALF_W-1:0]        i_name_high,
    input  logic [nrt_pkg::IDX_W-1:0]         i_entry_index,
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output logic [nrt_pkg::STATUS_W-1:0]      o_status,
    output logic                              o_matched,
    output logic [nrt_pkg::COUNT_OUT_W-1:0]   o_entry_count,
    output logic                              o_entry_valid,
    output logic [nrt_pkg::HALF_W-1:0]        o_entry_name_low,
    output logic [nrt_pkg::HALF_W-1:0]        o_entry_name_high
);

    logic          push;
    logic          full;
    logic          pop;
    logic          q_valid;
    nrt_pkg::t_job push_job;
    nrt_pkg::t_job head_job;

    // Front end: accept, normalize and classify.
    nrt_front #(
        .NAME_BYTES (NAME_BYTES)
    ) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_in_valid),
        .o_stall       (o_in_stall),
        .i_cmd         (i_cmd),
        .i_privileged  (i_privileged),
        .i_name_low    (i_name_low),
        .i_name_high   (i_name_high),
        .i_entry_index (i_entry_index),
        .o_push        (push),
        .o_job         (push_job),
        .i_full        (full)
    );

    // Job queue between the two ends.
    nrt_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (push_job),
        .o_full  (full),
        .i_pop   (pop),
        .o_valid (q_valid),
        .o_job   (head_job)
    );

    // Back end: table memory, sequencer and result register.
    nrt_back #(
        .MAX_ENTRIES (MAX_ENTRIES)
    ) u_back (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_q_valid         (q_valid),
        .i_q_job           (head_job),
        .o_pop             (pop),
        .o_valid           (o_out_valid),
        .i_stall           (i_out_stall),
        .o_status          (o_status),
        .o_matched         (o_matched),
        .o_entry_count     (o_entry_count),
        .o_entry_valid     (o_entry_valid),
        .o_entry_name_low  (o_entry_name_low),
        .o_entry_name_high (o_entry_name_high)
    );

endmodule
